// ===== design/psve_pkg.sv =====
package psve_pkg;

    localparam int PHASE_W      = 32;
    localparam int SINE_DEPTH   = 1024;
    localparam int SINE_AW      = $clog2(SINE_DEPTH);
    localparam int SAMPLE_RATE  = 48000;
    localparam int DEF_VOICES   = 8;
    localparam int NOTE_COUNT   = 128;

    localparam logic [1:0] ACT_NOTE_ON  = 2'd0;
    localparam logic [1:0] ACT_NOTE_OFF = 2'd1;
    localparam logic [1:0] ACT_TICK     = 2'd2;

    localparam logic [1:0] WAVE_SAW    = 2'd1;
    localparam logic [1:0] WAVE_SQUARE = 2'd2;

    localparam logic [2:0] REG_WAVEFORM    = 3'd0;
    localparam logic [2:0] REG_MASTER_GAIN = 3'd1;
    localparam logic [2:0] REG_OSC_ONE     = 3'd2;
    localparam logic [2:0] REG_OSC_TWO     = 3'd3;
    localparam logic [2:0] REG_ATTACK      = 3'd4;
    localparam logic [2:0] REG_RELEASE     = 3'd5;

    localparam logic [16:0] LEVEL_ONE     = 17'd65536;
    localparam logic [16:0] RELEASE_FLOOR = 17'd65;
    localparam logic [17:0] VOICE_VOLUME  = 18'd19661;

    localparam longint unsigned HalfPiQ30 = 64'd1686629713;
    localparam longint unsigned OneQ30    = 64'd1073741824;
    localparam longint unsigned PitchDen  = 64'(SAMPLE_RATE) << (32 - PHASE_W);

    typedef logic [PHASE_W-1:0] t_pitch_rom [NOTE_COUNT];
    typedef logic [15:0]        t_sine_rom  [SINE_DEPTH];

    function automatic longint unsigned semitone_q16(input int k);
        longint unsigned r;
        r = 64'd65536;
        case (k)
            0:  r = 64'd65536;
            1:  r = 64'd69433;
            2:  r = 64'd73562;
            3:  r = 64'd77936;
            4:  r = 64'd82570;
            5:  r = 64'd87480;
            6:  r = 64'd92682;
            7:  r = 64'd98193;
            8:  r = 64'd104032;
            9:  r = 64'd110218;
            10: r = 64'd116772;
            11: r = 64'd123715;
            default: r = 64'd65536;
        endcase
        return r;
    endfunction

    function automatic t_pitch_rom build_pitch_rom();
        t_pitch_rom      t;
        int              d;
        int              oct;
        longint unsigned x;
        longint unsigned q;
        for (int n = 0; n < NOTE_COUNT; n++) begin
            d    = n + 3;
            oct  = d / 12;
            x    = (64'd440 * semitone_q16(d % 12)) << (oct + 10);
            q    = (x + PitchDen / 2) / PitchDen;
            t[n] = q[PHASE_W-1:0];
        end
        return t;
    endfunction

    function automatic t_sine_rom build_sine_rom();
        t_sine_rom       t;
        longint unsigned four;
        longint unsigned quad;
        longint unsigned r;
        longint unsigned x;
        longint unsigned x2;
        longint unsigned c;
        longint unsigned s;
        longint          q;
        for (int i = 0; i < SINE_DEPTH; i++) begin
            four = 64'(i) * 4;
            quad = four / SINE_DEPTH;
            r    = four % SINE_DEPTH;
            if (quad[0]) begin
                r = SINE_DEPTH - r;
            end
            x  = r * HalfPiQ30 / SINE_DEPTH;
            x2 = (x * x) >> 30;
            c  = OneQ30 - x2 / 110;
            c  = OneQ30 - ((x2 * c) >> 30) / 72;
            c  = OneQ30 - ((x2 * c) >> 30) / 42;
            c  = OneQ30 - ((x2 * c) >> 30) / 20;
            c  = OneQ30 - ((x2 * c) >> 30) / 6;
            s  = (x * c) >> 30;
            q  = longint'((s + 64'd16384) >> 15);
            if (q > 32767) begin
                q = 32767;
            end
            if (quad >= 2) begin
                q = -q;
            end
            t[i] = q[15:0];
        end
        return t;
    endfunction

    localparam t_pitch_rom PITCH_ROM = build_pitch_rom();
    localparam t_sine_rom  SINE_ROM  = build_sine_rom();

endpackage

// ===== design/polyphonic_synth_voice_engine.sv =====
// Polyphonic voice engine, up to VOICE_COUNT voices, one shared 18x18 multiplier.
// Input channel (i_in_valid / o_in_stall) carries one word: action, note, velocity.
//   Note on takes the lowest free voice; with none free the note is dropped.
//   Note off releases every active voice holding that note.
//   Both are handled in the accept cycle and produce no output word.
// A sample tick walks every voice: an idle voice passes only S_ENV, an active one
// runs S_ENV through S_AC, all on the single multiplier, then S_FIN posts the mix.
//   o_in_stall is high while the tick runs, until S_FIN posts the mix.
// Output channel (o_out_valid / i_out_stall) carries one word per tick, left
// equal to right, Q1.15 clipped. The output register holds while stalled; a new
// tick may be accepted while the previous word still waits, but its own mix
// is held back until that word is taken.
// Configuration: i_cfg_we writes register i_cfg_index with i_cfg_data; write only
// while idle. Index 0 waveform, 1 master gain, 2/3 oscillator levels, 4 attack step,
// 5 release factor.
// Reset (synchronous, active low) frees every voice, loads the default registers
// and drops any pending output word.
module polyphonic_synth_voice_engine
    import psve_pkg::*;
#(
    parameter int VOICE_COUNT = DEF_VOICES
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [1:0]         i_action,
    input  logic [6:0]         i_note,
    input  logic [15:0]        i_velocity,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic signed [15:0] o_sample_left,
    output logic signed [15:0] o_sample_right,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_index,
    input  logic [16:0]        i_cfg_data
);

    localparam int VIDX_W = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1;
    localparam int MIX_W  = 16 + VIDX_W + 1;
    localparam logic [VIDX_W-1:0] LAST_VOICE = VIDX_W'(VOICE_COUNT - 1);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_ENV  = 4'd1;
    localparam logic [3:0] S_LV   = 4'd2;
    localparam logic [3:0] S_O1   = 4'd3;
    localparam logic [3:0] S_O2   = 4'd4;
    localparam logic [3:0] S_SQ   = 4'd5;
    localparam logic [3:0] S_CB   = 4'd6;
    localparam logic [3:0] S_GN   = 4'd7;
    localparam logic [3:0] S_VL   = 4'd8;
    localparam logic [3:0] S_SC   = 4'd9;
    localparam logic [3:0] S_AC   = 4'd10;
    localparam logic [3:0] S_FIN  = 4'd11;

    logic [1:0]  r_waveform;
    logic [15:0] r_master_gain;
    logic [15:0] r_osc_one;
    logic [15:0] r_osc_two;
    logic [16:0] r_attack;
    logic [15:0] r_release;

    logic               r_on  [VOICE_COUNT];
    logic               r_rel [VOICE_COUNT];
    logic [6:0]         r_key [VOICE_COUNT];
    logic [15:0]        r_vel [VOICE_COUNT];
    logic [16:0]        r_level [VOICE_COUNT];
    logic [PHASE_W-1:0] r_inc [VOICE_COUNT];
    logic [PHASE_W-1:0] r_ph1 [VOICE_COUNT];
    logic [PHASE_W-1:0] r_ph2 [VOICE_COUNT];

    logic [3:0]          r_state;
    logic [3:0]          n_state;
    logic [VIDX_W-1:0]   r_v;
    logic signed [MIX_W-1:0] r_mix;
    logic [16:0]         r_lvl;
    logic signed [15:0]  r_o1;
    logic signed [17:0]  r_sum;
    logic [16:0]         r_cube;
    logic [15:0]         r_gain;
    logic [15:0]         r_sine;
    logic signed [35:0]  r_prod;
    logic                r_out_valid;
    logic signed [15:0]  r_sample;

    logic signed [17:0]  m_a;
    logic signed [17:0]  m_b;
    logic signed [35:0]  m_p;
    logic signed [19:0]  prod_sh;
    logic                accept;
    logic                free_found;
    logic [VIDX_W-1:0]   free_idx;
    logic [SINE_AW-1:0]  sine_addr;
    logic [PHASE_W-1:0]  cur_ph;
    logic signed [15:0]  wave;
    logic [17:0]         att_sum;
    logic [16:0]         rel_lvl;
    logic [16:0]         new_lvl;
    logic                freed;
    logic                last_v;
    logic signed [MIX_W-1:0] mix_sum;
    logic signed [15:0]  mix_clip;
    logic                out_free;

    assign accept     = i_in_valid && !o_in_stall;
    assign o_in_stall = (r_state != S_IDLE);
    assign o_out_valid    = r_out_valid;
    assign o_sample_left  = r_sample;
    assign o_sample_right = r_sample;
    assign prod_sh  = r_prod[35:16];
    assign last_v   = (r_v == LAST_VOICE);
    assign out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int v = 0; v < VOICE_COUNT; v++) begin
            if (!free_found && !r_on[v]) begin
                free_found = 1'b1;
                free_idx   = VIDX_W'(v);
            end
        end
    end

    assign cur_ph    = (r_state == S_LV) ? r_ph1[r_v] : r_ph2[r_v];
    assign sine_addr = (r_state == S_ENV) ? r_ph1[r_v][PHASE_W-1 -: SINE_AW]
                                          : r_ph2[r_v][PHASE_W-1 -: SINE_AW];

    always_comb begin
        case (r_waveform)
            WAVE_SAW:    wave = {~cur_ph[PHASE_W-1], cur_ph[PHASE_W-2 -: 15]};
            WAVE_SQUARE: wave = (!cur_ph[PHASE_W-1] || (cur_ph[PHASE_W-2:0] == '0))
                                ? 16'sd32767 : -16'sd32767;
            default:     wave = $signed(r_sine);
        endcase
    end

    assign att_sum = {1'b0, r_level[r_v]} + {1'b0, r_attack};
    assign rel_lvl = prod_sh[16:0];
    always_comb begin
        freed   = 1'b0;
        new_lvl = att_sum[16:0];
        if (r_rel[r_v]) begin
            if (rel_lvl <= RELEASE_FLOOR) begin
                new_lvl = '0;
                freed   = 1'b1;
            end else begin
                new_lvl = rel_lvl;
            end
        end else if (att_sum >= {1'b0, LEVEL_ONE}) begin
            new_lvl = LEVEL_ONE;
        end
    end

    always_comb begin
        m_a = '0;
        m_b = '0;
        case (r_state)
            S_ENV: begin
                m_a = {1'b0, r_level[r_v]};
                m_b = {2'b0, r_release};
            end
            S_LV: begin
                m_a = 18'(wave);
                m_b = {2'b0, r_osc_one};
            end
            S_O1: begin
                m_a = 18'(wave);
                m_b = {2'b0, r_osc_two};
            end
            S_O2: begin
                m_a = {1'b0, r_lvl};
                m_b = {1'b0, r_lvl};
            end
            S_SQ: begin
                m_a = prod_sh[17:0];
                m_b = {1'b0, r_lvl};
            end
            S_CB: begin
                m_a = {2'b0, r_master_gain};
                m_b = {1'b0, LEVEL_ONE - {1'b0, r_vel[r_v]}};
            end
            S_GN: begin
                m_a = r_sum;
                m_b = VOICE_VOLUME;
            end
            S_VL: begin
                m_a = prod_sh[17:0];
                m_b = {1'b0, r_cube};
            end
            S_SC: begin
                m_a = prod_sh[17:0];
                m_b = {2'b0, r_gain};
            end
            default: begin
                m_a = '0;
                m_b = '0;
            end
        endcase
    end
    assign m_p = m_a * m_b;

    assign mix_sum = r_mix + MIX_W'(prod_sh);
    always_comb begin
        if (r_mix > MIX_W'(32767)) begin
            mix_clip = 16'sd32767;
        end else if (r_mix < -MIX_W'(32768)) begin
            mix_clip = -16'sd32768;
        end else begin
            mix_clip = r_mix[15:0];
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: if (accept && i_action == ACT_TICK) n_state = S_ENV;
            S_ENV: begin
                if (r_on[r_v]) begin
                    n_state = S_LV;
                end else if (last_v) begin
                    n_state = S_FIN;
                end
            end
            S_LV: n_state = S_O1;
            S_O1: n_state = S_O2;
            S_O2: n_state = S_SQ;
            S_SQ: n_state = S_CB;
            S_CB: n_state = S_GN;
            S_GN: n_state = S_VL;
            S_VL: n_state = S_SC;
            S_SC: n_state = S_AC;
            S_AC: n_state = last_v ? S_FIN : S_ENV;
            S_FIN: if (out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_prod <= m_p;
        r_sine <= SINE_ROM[sine_addr];
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_out_valid   <= 1'b0;
            r_waveform    <= '0;
            r_master_gain <= 16'hFFFF;
            r_osc_one     <= 16'hFFFF;
            r_osc_two     <= 16'hFFFF;
            r_attack      <= 17'd137;
            r_release     <= 16'd65000;
            r_v           <= '0;
            for (int v = 0; v < VOICE_COUNT; v++) begin
                r_on[v]  <= 1'b0;
                r_rel[v] <= 1'b0;
            end
        end else begin
            r_state <= n_state;
            if (r_out_valid && !i_out_stall && r_state != S_FIN) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_WAVEFORM:    r_waveform    <= i_cfg_data[1:0];
                    REG_MASTER_GAIN: r_master_gain <= i_cfg_data[15:0];
                    REG_OSC_ONE:     r_osc_one     <= i_cfg_data[15:0];
                    REG_OSC_TWO:     r_osc_two     <= i_cfg_data[15:0];
                    REG_ATTACK:      r_attack      <= i_cfg_data;
                    REG_RELEASE:     r_release     <= i_cfg_data[15:0];
                    default: ;
                endcase
            end
            case (r_state)
                S_IDLE: begin
                    r_v   <= '0;
                    r_mix <= '0;
                    if (accept && i_action == ACT_NOTE_ON && free_found) begin
                        r_on[free_idx]    <= 1'b1;
                        r_rel[free_idx]   <= 1'b0;
                        r_key[free_idx]   <= i_note;
                        r_vel[free_idx]   <= i_velocity;
                        r_level[free_idx] <= '0;
                        r_inc[free_idx]   <= PITCH_ROM[i_note];
                        r_ph1[free_idx]   <= '0;
                        r_ph2[free_idx]   <= '0;
                    end
                    if (accept && i_action == ACT_NOTE_OFF) begin
                        for (int v = 0; v < VOICE_COUNT; v++) begin
                            if (r_on[v] && r_key[v] == i_note) begin
                                r_rel[v] <= 1'b1;
                            end
                        end
                    end
                end
                S_ENV: begin
                    if (!r_on[r_v] && !last_v) begin
                        r_v <= r_v + 1'b1;
                    end
                end
                S_LV: begin
                    r_lvl          <= new_lvl;
                    r_level[r_v]   <= new_lvl;
                    if (freed) begin
                        r_on[r_v] <= 1'b0;
                    end
                end
                S_O1: r_o1 <= prod_sh[15:0];
                S_O2: r_sum <= 18'(r_o1) + prod_sh[17:0];
                S_CB: r_cube <= prod_sh[16:0];
                S_GN: r_gain <= prod_sh[15:0];
                S_AC: begin
                    r_mix      <= mix_sum;
                    r_ph1[r_v] <= r_ph1[r_v] + r_inc[r_v];
                    r_ph2[r_v] <= r_ph2[r_v] + {r_inc[r_v][PHASE_W-2:0], 1'b0};
                    if (!last_v) begin
                        r_v <= r_v + 1'b1;
                    end
                end
                S_FIN: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_sample    <= mix_clip;
                    end
                end
                default: ;
            endcase
        end
    end

    a_tick_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_action == ACT_TICK) |=> o_in_stall)
        else $error("tick accepted but engine not busy");

    a_level_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_O1) |-> (r_lvl <= LEVEL_ONE))
        else $error("envelope level above one");

    a_out_from_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state == S_FIN))
        else $error("output word posted outside finish");

    a_voice_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> (r_v <= LAST_VOICE))
        else $error("voice index out of range");

endmodule
